>>> src/fniw_pkg.sv
package fniw_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int PTR_W      = $clog2(WINDOW_MAX);
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int SAMPLE_W   = 32;
  localparam int WIN_W      = 7;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    ptr_t                       pos;
    logic signed [SAMPLE_W-1:0] value;
  } q_entry_t;

  localparam int ENTRY_W = $bits(q_entry_t);

  typedef struct packed {
    logic     push;
    logic     pop;
    logic     clr;
    q_entry_t entry;
  } q_ctl_t;

  typedef struct packed {
    cnt_t     count;
    q_entry_t front;
  } q_sts_t;

endpackage

>>> src/fniw_ram.sv
module fniw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/fniw_queue.sv
module fniw_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  fniw_pkg::q_ctl_t q_ctl,
  output fniw_pkg::q_sts_t q_sts
);
  import fniw_pkg::*;

  ptr_t     head_r, head_nxt;
  ptr_t     tail_r, tail_nxt;
  cnt_t     count_r, count_nxt;
  logic     fwd_r;
  q_entry_t fwd_data_r;
  logic [ENTRY_W-1:0] rd_data;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (q_ctl.clr) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else begin
      if (q_ctl.push) begin
        tail_nxt = tail_r + ptr_t'(1);
      end
      if (q_ctl.pop) begin
        head_nxt = head_r + ptr_t'(1);
      end
      count_nxt = count_r + cnt_t'(q_ctl.push) - cnt_t'(q_ctl.pop);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      fwd_r   <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      fwd_r   <= q_ctl.push && (tail_r == head_nxt);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= q_ctl.entry;
  end

  fniw_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(WINDOW_MAX)
  ) u_store (
    .clk    (clk),
    .wr_en  (q_ctl.push),
    .wr_addr(tail_r),
    .wr_data(q_ctl.entry),
    .rd_addr(head_nxt),
    .rd_data(rd_data)
  );

  assign q_sts.count = count_r;
  assign q_sts.front = fwd_r ? fwd_data_r : q_entry_t'(rd_data);

endmodule

>>> src/first_negative_in_window.sv
// Sliding-window first negative sample.
//
// Signed samples enter on the in_ channel, one transfer per cycle at most,
// with in_is_last marking the final sample of an array. Once window_size
// samples of the current array have arrived, every sample produces one
// transfer on the out_ channel: the oldest negative sample among the last
// window_size samples (zero with out_found low when there is none), and
// out_last_window set when the sample was the final one of its array.
// Samples before the window fills produce no result.
//
// A sample taken into the input register gives its result on out_valid from
// the result register, and the block sustains one sample per cycle unless
// out_stall holds the result register full. These two registers bracket the
// single processing stage; when out_stall holds the result register full,
// in_stall rises and the pending sample waits in the input register.
//
// Reset sets the window size to one and empties the history. A write on the
// cfg_ port sets the window size (zero acts as one, values above 64 act as
// 64) and restarts the stream, as does the end of an array.
module first_negative_in_window (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_write_en,
  input  logic [fniw_pkg::WIN_W-1:0]         cfg_window_size,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [fniw_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                               in_is_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [fniw_pkg::SAMPLE_W-1:0] out_first_negative,
  output logic                               out_found,
  output logic                               out_last_window
);
  import fniw_pkg::*;

  logic [WIN_W-1:0]          window_r;
  logic                      v1_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                      last_r;
  cnt_t                      fill_r, fill_nxt;
  ptr_t                      hp_r, hp_nxt;
  logic                      out_valid_r;
  logic signed [SAMPLE_W-1:0] out_value_r;
  logic                      out_found_r;
  logic                      out_last_r;

  logic     out_free;
  logic     adv;
  cnt_t     k;
  ptr_t     leave_pos;
  logic     emit;
  logic     q_empty;
  logic     have;
  q_entry_t front;
  q_ctl_t   q_ctl;
  q_sts_t   q_sts;

  always_comb begin
    if (window_r == '0) begin
      k = cnt_t'(1);
    end else if (window_r > WIN_W'(WINDOW_MAX)) begin
      k = cnt_t'(WINDOW_MAX);
    end else begin
      k = cnt_t'(window_r);
    end
  end

  assign out_free  = !out_valid_r || !out_stall;
  assign adv       = v1_r && out_free;
  assign in_stall  = v1_r && !out_free;
  assign leave_pos = hp_r - ptr_t'(k - cnt_t'(1));

  always_comb begin
    fill_nxt = (fill_r < k) ? fill_r + cnt_t'(1) : fill_r;
    emit     = fill_nxt >= k;
    q_empty  = q_sts.count == '0;

    q_ctl.entry.pos   = hp_r;
    q_ctl.entry.value = sample_r;
    q_ctl.push = adv && sample_r[SAMPLE_W-1] && (q_sts.count != cnt_t'(WINDOW_MAX));

    front = q_empty ? q_ctl.entry : q_sts.front;
    have  = !q_empty || q_ctl.push;

    q_ctl.pop = adv && emit && have && (front.pos == leave_pos);
    q_ctl.clr = cfg_write_en || (adv && last_r);

    hp_nxt = hp_r;
    if (q_ctl.clr) begin
      fill_nxt = '0;
      hp_nxt   = '0;
    end else if (adv) begin
      hp_nxt = hp_r + ptr_t'(1);
    end else begin
      fill_nxt = fill_r;
    end
  end

  fniw_queue u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .q_ctl(q_ctl),
    .q_sts(q_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= WIN_W'(1);
      v1_r        <= 1'b0;
      fill_r      <= '0;
      hp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        window_r <= cfg_window_size;
      end
      if (!in_stall) begin
        v1_r <= in_valid;
      end
      fill_r <= fill_nxt;
      hp_r   <= hp_nxt;
      if (out_free) begin
        out_valid_r <= adv && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      sample_r <= in_sample;
      last_r   <= in_is_last;
    end
    if (adv && emit) begin
      out_value_r <= have ? front.value : '0;
      out_found_r <= have;
      out_last_r  <= last_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_first_negative = out_value_r;
  assign out_found          = out_found_r;
  assign out_last_window    = out_last_r;

endmodule
